### src/dpwd_pkg.sv
// dpwd_pkg: shared types, constants and register indexes for the doorbell
// pulse width decoder. No dependencies.

package dpwd_pkg;

   localparam int WIDTH_BITS       = 16;
   localparam int SCALE_BITS       = 8;
   localparam int SCALED_BITS      = WIDTH_BITS + SCALE_BITS;
   localparam int CODE_BITS        = 12;
   localparam int ADDR_BITS        = 4;
   localparam int COUNT_BITS       = 6;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;
   localparam int FRAME_PULSES_DEF = 26;

   localparam logic [CODE_BITS-1:0] PREAMBLE_MASK = 12'hFF0;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

   localparam logic [WIDTH_BITS-1:0] START_PULSE_MAX_RST     = 16'd675;
   localparam logic [WIDTH_BITS-1:0] LONG_PULSE_MIN_RST      = 16'd800;
   localparam logic [WIDTH_BITS-1:0] LONG_PULSE_MAX_RST      = 16'd1275;
   localparam logic [WIDTH_BITS-1:0] SHORT_PULSE_MIN_RST     = 16'd250;
   localparam logic [WIDTH_BITS-1:0] GAP_AFTER_LONG_MAX_RST  = 16'd675;
   localparam logic [WIDTH_BITS-1:0] GAP_AFTER_SHORT_MIN_RST = 16'd700;
   localparam logic [SCALE_BITS-1:0] PULSE_SCALE_RST         = 8'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PULSE_SCALE         = 3'd0,
      CSR_START_PULSE_MAX     = 3'd1,
      CSR_LONG_PULSE_MIN      = 3'd2,
      CSR_LONG_PULSE_MAX      = 3'd3,
      CSR_SHORT_PULSE_MIN     = 3'd4,
      CSR_GAP_AFTER_LONG_MAX  = 3'd5,
      CSR_GAP_AFTER_SHORT_MIN = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_COUNT    = 2'd1,
      STATUS_TIMING   = 2'd2,
      STATUS_PREAMBLE = 2'd3
   } status_type;

   typedef struct packed {
      logic [SCALE_BITS-1:0] pulse_scale;
      logic [WIDTH_BITS-1:0] start_pulse_max;
      logic [WIDTH_BITS-1:0] long_pulse_min;
      logic [WIDTH_BITS-1:0] long_pulse_max;
      logic [WIDTH_BITS-1:0] short_pulse_min;
      logic [WIDTH_BITS-1:0] gap_after_long_max;
      logic [WIDTH_BITS-1:0] gap_after_short_min;
   } cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic [WIDTH_BITS-1:0] width;
   } step_type;

   typedef struct packed {
      status_type            status;
      logic [CODE_BITS-1:0]  code;
   } result_type;

endpackage

### src/dpwd_req_if.sv
// dpwd_req_if: valid/ready channel carrying one captured pulse word.
// Depends on dpwd_pkg.

interface dpwd_req_if;
   logic                            valid;
   logic                            ready;
   logic [dpwd_pkg::WIDTH_BITS-1:0] pulse_width;
   logic                            is_last;

   modport source (output valid, output pulse_width, output is_last, input ready);
   modport sink   (input valid, input pulse_width, input is_last, output ready);
endinterface

### src/dpwd_rsp_if.sv
// dpwd_rsp_if: valid/ready channel carrying one decoded frame word.
// Depends on dpwd_pkg.

interface dpwd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     frame_status;
   logic [dpwd_pkg::CODE_BITS-1:0] code_word;
   logic [dpwd_pkg::ADDR_BITS-1:0] address;

   modport source (output valid, output frame_status, output code_word, output address,
                   input ready);
   modport sink   (input valid, input frame_status, input code_word, input address,
                   output ready);
endinterface

### src/dpwd_frame.sv
// dpwd_frame: per-frame state (pulse count, bits, error flag) and the
// scale-and-compare step for one pulse. Depends on dpwd_pkg.

module dpwd_frame #(
   parameter int FRAME_PULSES = dpwd_pkg::FRAME_PULSES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dpwd_pkg::cfg_type    cfg,
   input  dpwd_pkg::step_type   step,
   output dpwd_pkg::result_type result
);

   localparam logic [dpwd_pkg::COUNT_BITS-1:0] FRAME_CNT =
      dpwd_pkg::COUNT_BITS'(FRAME_PULSES);

   logic [dpwd_pkg::COUNT_BITS-1:0]  count_ff, count_in, pos;
   logic [dpwd_pkg::CODE_BITS-1:0]   bits_ff, bits_in, bits_upd;
   logic                             err_ff, err_in, err_upd;
   logic                             long_ff, long_in, long_upd;
   logic [dpwd_pkg::SCALED_BITS-1:0] scaled;
   logic                             is_start, pair_first, pair_second, is_long;

   always_comb begin
      scaled = dpwd_pkg::SCALED_BITS'(step.width) * dpwd_pkg::SCALED_BITS'(cfg.pulse_scale);
      pos = (count_ff == dpwd_pkg::COUNT_MAX) ? count_ff : count_ff + 1'b1;
      is_start    = (pos == dpwd_pkg::COUNT_BITS'(1));
      pair_first  = !pos[0] && (pos < FRAME_CNT);
      pair_second = pos[0] && !is_start && (pos <= FRAME_CNT);
      is_long = scaled > dpwd_pkg::SCALED_BITS'(cfg.long_pulse_min);

      bits_upd = bits_ff;
      err_upd  = err_ff;
      long_upd = long_ff;
      priority if (is_start) begin
         if (scaled > dpwd_pkg::SCALED_BITS'(cfg.start_pulse_max)) err_upd = 1'b1;
      end else if (pair_first) begin
         long_upd = is_long;
         bits_upd = {bits_ff[dpwd_pkg::CODE_BITS-2:0], is_long};
         if (is_long) begin
            if (scaled > dpwd_pkg::SCALED_BITS'(cfg.long_pulse_max)) err_upd = 1'b1;
         end else begin
            if (scaled < dpwd_pkg::SCALED_BITS'(cfg.short_pulse_min)) err_upd = 1'b1;
         end
      end else if (pair_second) begin
         if (long_ff) begin
            if (scaled > dpwd_pkg::SCALED_BITS'(cfg.gap_after_long_max)) err_upd = 1'b1;
         end else begin
            if (scaled < dpwd_pkg::SCALED_BITS'(cfg.gap_after_short_min)) err_upd = 1'b1;
         end
      end else begin
         err_upd = err_ff;
      end

      // frame result
      result.code = bits_upd;
      priority if (pos != FRAME_CNT) begin
         result.status = dpwd_pkg::STATUS_COUNT;
         result.code   = '0;
      end else if (err_upd) begin
         result.status = dpwd_pkg::STATUS_TIMING;
         result.code   = '0;
      end else if ((bits_upd & dpwd_pkg::PREAMBLE_MASK) != dpwd_pkg::PREAMBLE_MASK) begin
         result.status = dpwd_pkg::STATUS_PREAMBLE;
      end else begin
         result.status = dpwd_pkg::STATUS_OK;
      end

      count_in = count_ff;
      bits_in  = bits_ff;
      err_in   = err_ff;
      long_in  = long_ff;
      if (step.valid) begin
         if (step.last) begin
            count_in = '0;
            bits_in  = '0;
            err_in   = 1'b0;
            long_in  = 1'b0;
         end else begin
            count_in = pos;
            bits_in  = bits_upd;
            err_in   = err_upd;
            long_in  = long_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         bits_ff  <= '0;
         err_ff   <= 1'b0;
         long_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         bits_ff  <= bits_in;
         err_ff   <= err_in;
         long_ff  <= long_in;
      end
   end

endmodule

### src/doorbell_pulse_width_decoder.sv
// Pulse width decoder for a 12-bit doorbell remote frame: one pulse word
// in, one decoded frame word out at each last pulse. A new input word can
// be accepted every cycle; the only stall is a last pulse that waits in the
// input register while the previous frame word is still held unaccepted on
// the result side. The last pulse passes through the input register, and
// its frame word is registered in the result register. The rate is set by
// the frame state update (multiply, compare, shift), which is combinational
// between the input register and the frame state and result registers.
// Depends on dpwd_pkg, dpwd_req_if, dpwd_rsp_if and dpwd_frame.

module doorbell_pulse_width_decoder #(
   parameter int FRAME_PULSES = dpwd_pkg::FRAME_PULSES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   dpwd_req_if.sink                            req_word,
   dpwd_rsp_if.source                          rsp_word,
   input  logic                                csr_we,
   input  logic [dpwd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dpwd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   dpwd_pkg::cfg_type    cfg_ff, cfg_in;
   dpwd_pkg::step_type   step;
   dpwd_pkg::result_type result;

   logic                            in_valid_ff, in_valid_in;
   logic                            in_last_ff;
   logic [dpwd_pkg::WIDTH_BITS-1:0] in_width_ff;
   logic                            out_valid_ff, out_valid_in;
   dpwd_pkg::result_type            out_ff;
   logic                            out_free, advance, take;

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dpwd_pkg::CSR_PULSE_SCALE:
               cfg_in.pulse_scale = csr_wdata[dpwd_pkg::SCALE_BITS-1:0];
            dpwd_pkg::CSR_START_PULSE_MAX:     cfg_in.start_pulse_max     = csr_wdata;
            dpwd_pkg::CSR_LONG_PULSE_MIN:      cfg_in.long_pulse_min      = csr_wdata;
            dpwd_pkg::CSR_LONG_PULSE_MAX:      cfg_in.long_pulse_max      = csr_wdata;
            dpwd_pkg::CSR_SHORT_PULSE_MIN:     cfg_in.short_pulse_min     = csr_wdata;
            dpwd_pkg::CSR_GAP_AFTER_LONG_MAX:  cfg_in.gap_after_long_max  = csr_wdata;
            dpwd_pkg::CSR_GAP_AFTER_SHORT_MIN: cfg_in.gap_after_short_min = csr_wdata;
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_scale         <= dpwd_pkg::PULSE_SCALE_RST;
         cfg_ff.start_pulse_max     <= dpwd_pkg::START_PULSE_MAX_RST;
         cfg_ff.long_pulse_min      <= dpwd_pkg::LONG_PULSE_MIN_RST;
         cfg_ff.long_pulse_max      <= dpwd_pkg::LONG_PULSE_MAX_RST;
         cfg_ff.short_pulse_min     <= dpwd_pkg::SHORT_PULSE_MIN_RST;
         cfg_ff.gap_after_long_max  <= dpwd_pkg::GAP_AFTER_LONG_MAX_RST;
         cfg_ff.gap_after_short_min <= dpwd_pkg::GAP_AFTER_SHORT_MIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake and pipeline control
   always_comb begin
      out_free = !out_valid_ff || rsp_word.ready;
      advance  = in_valid_ff && (!in_last_ff || out_free);
      req_word.ready = !in_valid_ff || advance;
      take     = req_word.valid && req_word.ready;

      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_word.ready);

      step.valid = advance;
      step.last  = in_last_ff;
      step.width = in_width_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_width_ff <= req_word.pulse_width;
         in_last_ff  <= req_word.is_last;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   dpwd_frame #(
      .FRAME_PULSES (FRAME_PULSES)
   ) u_frame (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .step   (step),
      .result (result)
   );

   assign rsp_word.valid        = out_valid_ff;
   assign rsp_word.frame_status = out_ff.status;
   assign rsp_word.code_word    = out_ff.code;
   assign rsp_word.address      = out_ff.code[dpwd_pkg::ADDR_BITS-1:0];

endmodule

### src/dpwd_checker.sv
// dpwd_checker: port-level assertions for the doorbell pulse width decoder,
// bound to the top level. Depends on dpwd_pkg and doorbell_pulse_width_decoder.

module dpwd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_status,
   input logic [dpwd_pkg::CODE_BITS-1:0] rsp_code,
   input logic [dpwd_pkg::ADDR_BITS-1:0] rsp_address
);

   // word held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_status))
      else $error("rsp word dropped or changed while stalled");

   a_no_word_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp word right after reset");

   a_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_address == rsp_code[dpwd_pkg::ADDR_BITS-1:0])
      else $error("address differs from low code bits");

   a_failed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dpwd_pkg::STATUS_COUNT ||
                    rsp_status == dpwd_pkg::STATUS_TIMING) |-> rsp_code == '0)
      else $error("failed frame carries code bits");

   a_ok_preamble: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dpwd_pkg::STATUS_OK |->
         (rsp_code & dpwd_pkg::PREAMBLE_MASK) == dpwd_pkg::PREAMBLE_MASK)
      else $error("ok frame without full preamble");

endmodule

bind doorbell_pulse_width_decoder dpwd_checker u_dpwd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_word.valid),
   .rsp_ready   (rsp_word.ready),
   .rsp_status  (rsp_word.frame_status),
   .rsp_code    (rsp_word.code_word),
   .rsp_address (rsp_word.address)
);
